// ===== rtl/ped_pkg.sv =====
// Shared types, constants and the control program of the distance engine.
package ped_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int MAX_COORDS_DEF = 16;

	localparam int PT_W        = 6;
	localparam int CI_W        = 4;
	localparam int CV_W        = 16;
	localparam int CFG_W       = 5;
	localparam int DIST_W      = 18;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;
	localparam int PC_W        = 3;

	localparam logic [CFG_W-1:0]  COORDS_RST = 5'd16;
	localparam logic [DIST_W-1:0] DIST_MAX   = 18'h3FFFF;
	localparam logic              ACT_WRITE  = 1'b0;

	// Program steps
	localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
	localparam logic [PC_W-1:0] STEP_DECODE = 3'd1;
	localparam logic [PC_W-1:0] STEP_READ   = 3'd2;
	localparam logic [PC_W-1:0] STEP_DRAIN1 = 3'd3;
	localparam logic [PC_W-1:0] STEP_DRAIN2 = 3'd4;
	localparam logic [PC_W-1:0] STEP_SQINIT = 3'd5;
	localparam logic [PC_W-1:0] STEP_SQRT   = 3'd6;
	localparam logic [PC_W-1:0] STEP_OUT    = 3'd7;

	typedef enum logic [2:0] {
		C_NEXT,
		C_NO_ITEM,
		C_IS_WRITE,
		C_K_MORE,
		C_ROOT_MORE,
		C_OUT_BUSY
	} ped_cond_t;

	typedef struct packed {
		logic            in_ready;
		logic            mem_wr;
		logic            clr_acc;
		logic            rd_issue;
		logic            sqrt_init;
		logic            sqrt_step;
		logic            out_load;
		ped_cond_t       cond;
		logic [PC_W-1:0] target;
	} ped_cw_t;

	typedef struct packed {
		logic is_write;
		logic k_more;
		logic root_more;
		logic out_busy;
	} ped_stat_t;

	// Taken jump goes to target, otherwise pc+1 (the last step wraps to idle).
	function automatic ped_cw_t ped_rom(input logic [PC_W-1:0] pc);
		ped_cw_t cw;
		cw        = '0;
		cw.cond   = C_NEXT;
		cw.target = STEP_IDLE;
		case (pc)
			STEP_IDLE: begin
				cw.in_ready = 1'b1;
				cw.cond     = C_NO_ITEM;
				cw.target   = STEP_IDLE;
			end
			STEP_DECODE: begin
				cw.mem_wr  = 1'b1;
				cw.clr_acc = 1'b1;
				cw.cond    = C_IS_WRITE;
				cw.target  = STEP_IDLE;
			end
			STEP_READ: begin
				cw.rd_issue = 1'b1;
				cw.cond     = C_K_MORE;
				cw.target   = STEP_READ;
			end
			STEP_DRAIN1: begin
			end
			STEP_DRAIN2: begin
			end
			STEP_SQINIT: begin
				cw.sqrt_init = 1'b1;
			end
			STEP_SQRT: begin
				cw.sqrt_step = 1'b1;
				cw.cond      = C_ROOT_MORE;
				cw.target    = STEP_SQRT;
			end
			STEP_OUT: begin
				cw.out_load = 1'b1;
				cw.cond     = C_OUT_BUSY;
				cw.target   = STEP_OUT;
			end
			default: begin
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== rtl/ped_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module ped_seq
	import ped_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ped_stat_t stat,
	output ped_cw_t   cw
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign cw = ped_rom(pc_q);

	always_comb begin
		case (cw.cond)
			C_NEXT:      take = 1'b0;
			C_NO_ITEM:   take = !in_valid;
			C_IS_WRITE:  take = stat.is_write;
			C_K_MORE:    take = stat.k_more;
			C_ROOT_MORE: take = stat.root_more;
			C_OUT_BUSY:  take = stat.out_busy;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (take) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

// ===== rtl/ped_store.sv =====
// Coordinate store: one write port, two registered read ports.
module ped_store
	import ped_pkg::*;
#(
	parameter int AW = 10
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [CV_W-1:0] wr_data,
	input  logic [AW-1:0]   rd_addr_a,
	input  logic [AW-1:0]   rd_addr_b,
	output logic [CV_W-1:0] rd_a_s1,
	output logic [CV_W-1:0] rd_b_s1
);

	localparam int DEPTH = 1 << AW;

	logic [CV_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_s1 <= mem[rd_addr_a];
		rd_b_s1 <= mem[rd_addr_b];
	end

endmodule

// ===== rtl/ped_dp.sv =====
// Datapath: item latch, store access, square-accumulate, bitwise root, result register.
module ped_dp
	import ped_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_COORDS = MAX_COORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ped_cw_t           cw,
	input  logic              accept,
	input  logic              in_action,
	input  logic [PT_W-1:0]   in_first_point,
	input  logic [PT_W-1:0]   in_second_point,
	input  logic [CI_W-1:0]   in_coord_index,
	input  logic [CV_W-1:0]   in_coord_value,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_value,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [DIST_W-1:0] out_distance,
	output ped_stat_t         stat
);

	localparam int PW  = $clog2(MAX_POINTS);
	localparam int CW  = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
	localparam int KW  = $clog2(MAX_COORDS + 1);
	localparam int AW  = PW + CW;
	localparam int SW  = 32 + KW;
	localparam int RW  = (SW + 1) / 2;
	localparam int VW  = 2 * RW;
	localparam int CNW = $clog2(RW + 1);

	logic              act_q;
	logic [PT_W-1:0]   p1_q;
	logic [PT_W-1:0]   p2_q;
	logic [CI_W-1:0]   ci_q;
	logic [CV_W-1:0]   cv_q;
	logic [CFG_W-1:0]  coords_q;
	logic [KW-1:0]     k_q;
	logic              rd_v_s1;
	logic [31:0]       sq_s2;
	logic              mul_v_s2;
	logic [SW-1:0]     acc_q;
	logic [VW-1:0]     v_q;
	logic [RW+1:0]     rem_q;
	logic [RW-1:0]     root_q;
	logic [CNW-1:0]    cnt_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] out_data_q;

	logic              p1_ok, p2_ok, ci_ok, k_more, issue, wr_en, out_busy;
	logic [CV_W-1:0]   rd_a_s1, rd_b_s1, a_val, b_val;
	logic signed [CV_W:0] diff;
	logic [CV_W-1:0]   mag;
	logic [RW+3:0]     sq_tmp, sq_trial;
	logic [DIST_W-1:0] dist_sat;

	// Item latch
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_action;
			p1_q  <= in_first_point;
			p2_q  <= in_second_point;
			ci_q  <= in_coord_index;
			cv_q  <= in_coord_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coords_q <= COORDS_RST;
		end else if (cfg_we) begin
			coords_q <= cfg_value;
		end
	end

	assign p1_ok  = 32'(p1_q) < 32'(MAX_POINTS);
	assign p2_ok  = 32'(p2_q) < 32'(MAX_POINTS);
	assign ci_ok  = 32'(ci_q) < 32'(MAX_COORDS);
	assign k_more = (32'(k_q) < 32'(coords_q)) && (32'(k_q) < 32'(MAX_COORDS));
	assign issue  = cw.rd_issue && k_more;
	assign wr_en  = cw.mem_wr && (act_q == ACT_WRITE) && p1_ok && ci_ok;

	ped_store #(
		.AW(AW)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   ({PW'(p1_q), CW'(ci_q)}),
		.wr_data   (cv_q),
		.rd_addr_a ({PW'(p1_q), k_q[CW-1:0]}),
		.rd_addr_b ({PW'(p2_q), k_q[CW-1:0]}),
		.rd_a_s1   (rd_a_s1),
		.rd_b_s1   (rd_b_s1)
	);

	// Points beyond the store read as zero
	assign a_val = p1_ok ? rd_a_s1 : '0;
	assign b_val = p2_ok ? rd_b_s1 : '0;
	assign diff  = $signed({a_val[CV_W-1], a_val}) - $signed({b_val[CV_W-1], b_val});
	assign mag   = diff[CV_W] ? CV_W'(-diff) : diff[CV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			if (cw.clr_acc) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + KW'(1);
			end
			rd_v_s1  <= issue;
			mul_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s2 <= 32'(mag) * 32'(mag);
		if (cw.clr_acc) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + SW'(sq_s2);
		end
	end

	// One root bit per step, two radicand bits shifted in each time
	assign sq_tmp   = {rem_q, v_q[VW-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cw.sqrt_init) begin
			v_q    <= VW'(acc_q);
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNW'(RW);
		end else if (cw.sqrt_step) begin
			v_q   <= {v_q[VW-3:0], 2'b00};
			cnt_q <= cnt_q - CNW'(1);
			if (sq_tmp >= sq_trial) begin
				rem_q  <= (RW+2)'(sq_tmp - sq_trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= (RW+2)'(sq_tmp);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign dist_sat = (32'(root_q) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_q);
	assign out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.out_load && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_load && !out_busy) begin
			out_data_q <= dist_sat;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_distance   = out_data_q;
	assign stat.is_write  = (act_q == ACT_WRITE);
	assign stat.k_more    = k_more;
	assign stat.root_more = (cnt_q != CNW'(1));
	assign stat.out_busy  = out_busy;

endmodule

// ===== rtl/pairwise_euclidean_distance.sv =====
// Top level of the pairwise Euclidean distance engine.
//
//  channel  | signals                        | beat
//  ---------+--------------------------------+----------------------------------------
//  cfg      | cfg_valid/ready, cfg_data[4:0] | coords_in_use
//  s_axis   | tvalid/tready, tdata, tuser    | coordinate write or distance query
//  m_axis   | tvalid/tready, tdata           | distance, unsigned integer (Q18.0)
//
// A write is stored in the decode step. A query runs serial store reads, one per
// coordinate summed, the drain steps, the root init and the one-bit-per-step square
// root loop (RW = 19 root bits at default sizes) before loading the output register.
// Reset clears control only; the coordinate store is not cleared and has no reset pass.
// A finished result waits in the output register while the next item is taken; a
// second result waits in the sequencer until the first beat leaves.
module pairwise_euclidean_distance
	import ped_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_COORDS = MAX_COORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// first_point[5:0], second_point[11:6], coord_index[15:12], coord_value[31:16]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// action[0]
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// distance[17:0], zero pad [23:18]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	ped_cw_t           cw;
	ped_stat_t         stat;
	logic [DIST_W-1:0] distance;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = cw.in_ready;

	ped_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.cw       (cw)
	);

	ped_dp #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_COORDS(MAX_COORDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cw              (cw),
		.accept          (s_axis_tvalid && s_axis_tready),
		.in_action       (s_axis_tuser),
		.in_first_point  (s_axis_tdata[5:0]),
		.in_second_point (s_axis_tdata[11:6]),
		.in_coord_index  (s_axis_tdata[15:12]),
		.in_coord_value  (s_axis_tdata[31:16]),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_value       (cfg_data),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_distance    (distance),
		.stat            (stat)
	);

	assign m_axis_tdata = {(OUT_TDATA_W-DIST_W)'(0), distance};

endmodule

// ===== rtl/ped_chk.sv =====
// Port-level checks on the distance engine, bound to the top level.
module ped_chk
	import ped_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed under stall");

	// Decode step follows every accepted item
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken in the decode step");

	// A query never finishes in the cycle after its acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared right after an accept");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:DIST_W] == '0)
		else $error("pad bits of result set");

endmodule

bind pairwise_euclidean_distance ped_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/pairwise_euclidean_distance_tb.sv =====
// Testbench for pairwise_euclidean_distance: directed table, then random writes and queries.
`timescale 1ns / 1ps

module pairwise_euclidean_distance_tb;
	import ped_pkg::*;

	localparam int NUM_POINTS   = MAX_POINTS_DEF;
	localparam int NUM_COORDS   = MAX_COORDS_DEF;
	localparam int CLK_HALF     = 6;
	localparam int DRAIN_CYCLES = 64;
	localparam int SEG_STEPS    = 60;
	localparam int MAX_REPORTS  = 10;
	localparam logic ACT_QUERY  = ~ACT_WRITE;

	typedef enum {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [PT_W-1:0]   pa;
		logic [PT_W-1:0]   pb;
		logic [CI_W-1:0]   ci;
		logic [CV_W-1:0]   val;
		bit                typed;
		logic [DIST_W-1:0] exp_dist;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// first_point[5:0], second_point[11:6], coord_index[15:12], coord_value[31:16]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// action[0]
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// distance[17:0], zero pad [23:18]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow of the coordinate store and the coordinate count
	logic signed [CV_W-1:0] coord_store [NUM_POINTS][NUM_COORDS];
	logic [NUM_COORDS-1:0]  coord_written [NUM_POINTS];
	logic [CFG_W-1:0]       coords_used;
	logic [DIST_W-1:0]      dist_q [$];

	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	stim_row_t dir_rows [24] = '{
		'{ROW_CFG,   0,  0,  0,  16'd1,    0, 0},
		'{ROW_WRITE, 0,  0,  0,  16'h8000, 0, 0},
		'{ROW_WRITE, 1,  0,  0,  16'h7FFF, 0, 0},
		'{ROW_QUERY, 0,  1,  0,  16'h0000, 1, 18'd65535},
		'{ROW_QUERY, 1,  0,  0,  16'h0000, 1, 18'd65535},
		'{ROW_QUERY, 0,  0,  0,  16'h0000, 1, 18'd0},
		// zero coordinates summed
		'{ROW_CFG,   0,  0,  0,  16'd0,    0, 0},
		'{ROW_QUERY, 0,  1,  0,  16'h0000, 1, 18'd0},
		'{ROW_CFG,   0,  0,  0,  16'd2,    0, 0},
		'{ROW_WRITE, 0,  0,  1,  16'h0100, 0, 0},
		'{ROW_WRITE, 1,  0,  1,  16'hFF00, 0, 0},
		'{ROW_QUERY, 0,  1,  0,  16'h0000, 0, 0},
		'{ROW_WRITE, 63, 0,  0,  16'hFFFF, 0, 0},
		'{ROW_WRITE, 63, 0,  1,  16'h0001, 0, 0},
		'{ROW_QUERY, 63, 0,  0,  16'h0000, 0, 0},
		'{ROW_QUERY, 63, 63, 0,  16'h0000, 1, 18'd0},
		'{ROW_WRITE, 62, 63, 15, 16'h1234, 0, 0},
		'{ROW_WRITE, 62, 0,  0,  16'h0000, 0, 0},
		'{ROW_WRITE, 62, 0,  1,  16'h0000, 0, 0},
		'{ROW_QUERY, 62, 1,  0,  16'h0000, 0, 0},
		'{ROW_CFG,   0,  0,  0,  16'd1,    0, 0},
		// ignored fields of a query held high
		'{ROW_QUERY, 1,  63, 15, 16'hFFFF, 0, 0},
		'{ROW_WRITE, 1,  0,  0,  16'h8000, 0, 0},
		'{ROW_QUERY, 1,  0,  0,  16'h0000, 1, 18'd0}
	};

	pairwise_euclidean_distance u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#20ms;
		$display("timeout with %0d distances outstanding", dist_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int coords_summed();
		return (coords_used > NUM_COORDS) ? NUM_COORDS : int'(coords_used);
	endfunction

	// floor of the root of the summed squared differences, saturated to the output width
	function automatic logic [DIST_W-1:0] calc_distance(int pa, int pb);
		longint unsigned acc;
		longint unsigned root;
		longint unsigned cand;
		longint diff;
		acc  = 0;
		root = 0;
		for (int k = 0; k < coords_summed(); k++) begin
			diff = longint'(coord_store[pa][k]) - longint'(coord_store[pb][k]);
			acc += longint'(diff * diff);
		end
		for (int b = DIST_W + 1; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= acc) begin
				root = cand;
			end
		end
		return (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
	endfunction

	function automatic bit point_ready(int p);
		logic [NUM_COORDS-1:0] need;
		need = (coords_summed() == NUM_COORDS) ? '1 : ((16'd1 << coords_summed()) - 16'd1);
		return (coord_written[p] & need) == need;
	endfunction

	function automatic int pick_ready_point();
		int p;
		p = $urandom_range(NUM_POINTS - 1);
		while (!point_ready(p)) begin
			p = $urandom_range(NUM_POINTS - 1);
		end
		return p;
	endfunction

	function automatic logic [CV_W-1:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// enter and leave at a falling edge; tvalid stays high if the next beat follows at once
	task automatic send_beat(input logic act, input logic [PT_W-1:0] pa,
			input logic [PT_W-1:0] pb, input logic [CI_W-1:0] ci, input logic [CV_W-1:0] cv,
			input bit typed, input logic [DIST_W-1:0] typed_dist);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {cv, ci, pb, pa};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		if (act == ACT_WRITE) begin
			coord_store[pa][ci]   = cv;
			coord_written[pa][ci] = 1'b1;
		end else begin
			dist_q.push_back(typed ? typed_dist : calc_distance(int'(pa), int'(pb)));
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (dist_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_coords_used(input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		coords_used = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic query_pair(input int pa, input int pb);
		send_beat(ACT_QUERY, PT_W'(pa), PT_W'(pb), CI_W'($urandom_range(15)),
			16'($urandom), 0, '0);
	endtask

	always @(negedge clk) begin
		m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (dist_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("distance beat with nothing expected: %0d",
						m_axis_tdata[DIST_W-1:0]);
				end
			end else if (m_axis_tdata[DIST_W-1:0] !== dist_q[0]) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("distance mismatch: expected %0d, got %0d",
						dist_q[0], m_axis_tdata[DIST_W-1:0]);
				end
				void'(dist_q.pop_front());
			end else begin
				void'(dist_q.pop_front());
			end
		end
	end

	initial begin
		int last_burst;
		int p;
		int mode;
		int seg;
		logic [CV_W-1:0] val;
		last_burst = 0;
		seg = 0;
		for (int i = 0; i < NUM_POINTS; i++) begin
			coord_written[i] = '0;
		end
		coords_used = COORDS_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			case (dir_rows[r].kind)
				ROW_CFG: begin
					write_coords_used(dir_rows[r].val[CFG_W-1:0]);
				end
				ROW_WRITE: begin
					send_beat(ACT_WRITE, dir_rows[r].pa, dir_rows[r].pb, dir_rows[r].ci,
						dir_rows[r].val, 0, '0);
				end
				default: begin
					send_beat(ACT_QUERY, dir_rows[r].pa, dir_rows[r].pb, dir_rows[r].ci,
						dir_rows[r].val, dir_rows[r].typed, dir_rows[r].exp_dist);
				end
			endcase
		end

		// fill every fourth point and the top one so queries always have legal partners
		write_coords_used(5'd16);
		for (int q = 0; q < NUM_POINTS; q++) begin
			if (q % 4 == 0 || q == NUM_POINTS - 1) begin
				for (int c = 0; c < NUM_COORDS; c++) begin
					send_beat(ACT_WRITE, PT_W'(q), PT_W'($urandom_range(63)), CI_W'(c),
						rand_coord(), 0, '0);
				end
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			for (int s = 0; s < 4; s++) begin
				case (seg % 8)
					0: write_coords_used(5'd16);
					1: write_coords_used(5'd1);
					2: write_coords_used(5'd31);
					3: write_coords_used(5'd0);
					4: write_coords_used(5'd17);
					default: write_coords_used(5'($urandom_range(31)));
				endcase
				seg++;
				for (int st = 0; st < SEG_STEPS; st++) begin
					mode = $urandom_range(99);
					if (mode < 55) begin
						p = pick_ready_point();
						query_pair(p, ($urandom_range(7) == 0) ? p : pick_ready_point());
					end else if (mode < 95) begin
						send_beat(ACT_WRITE, PT_W'($urandom_range(63)),
							PT_W'($urandom_range(63)), CI_W'($urandom_range(15)),
							rand_coord(), 0, '0);
					end else begin
						// rewrite one whole point, then measure it against the last rewritten point if that one is ready
						p = $urandom_range(NUM_POINTS - 1);
						mode = $urandom_range(2);
						for (int c = 0; c < NUM_COORDS; c++) begin
							val = (mode == 0) ? 16'h7FFF : (mode == 1) ? 16'h8000 : rand_coord();
							send_beat(ACT_WRITE, PT_W'(p), PT_W'($urandom_range(63)), CI_W'(c),
								val, 0, '0);
						end
						query_pair(p, point_ready(last_burst) ? last_burst : pick_ready_point());
						last_burst = p;
					end
				end
			end
		end

		wait_drained();
		if (mismatch_count == 0 && dist_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (dist_q.size() != 0) begin
				$display("%0d distances never arrived", dist_q.size());
			end
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
